// ----- hdl/line_box_filter_padded_defines.svh -----
// ----------------------------------------------------------------------------
// line_box_filter_padded_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LINE_BOX_FILTER_PADDED_DEFINES_SVH
`define LINE_BOX_FILTER_PADDED_DEFINES_SVH

// same-cycle implication, suspended during reset
`define LBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbf assertion failed");

// next-cycle implication, suspended during reset
`define LBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbf assertion failed");

// next-cycle implication, also checked across reset
`define LBF_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbf assertion failed");

`endif

// ----- hdl/lbf_pkg.sv -----
// ----------------------------------------------------------------------------
// lbf_pkg
// Widths, register indexes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package lbf_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int RADIUS_W  = 4;
  localparam int PAD_W     = 8;
  localparam int DEPTH_W   = 5;
  localparam int SUM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD    = 2'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
  localparam logic [PAD_W-1:0]    PAD_RST    = 8'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } ring_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/lbf_in_if.sv -----
// ----------------------------------------------------------------------------
// lbf_in_if
// Sample channel: valid/ready handshake with sample and end-of-line flag.
// ----------------------------------------------------------------------------
interface lbf_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbf_pkg::SAMPLE_W-1:0] sample;
  logic                      line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

// ----- hdl/lbf_out_if.sv -----
// ----------------------------------------------------------------------------
// lbf_out_if
// Result channel: valid/ready handshake with smoothed cell and last flag.
// ----------------------------------------------------------------------------
interface lbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [lbf_pkg::SAMPLE_W-1:0] smoothed;
  logic                      last_of_line;

  modport source (output valid, output smoothed, output last_of_line, input ready);
  modport sink   (input valid, input smoothed, input last_of_line, output ready);
endinterface

// ----- hdl/lbf_ring.sv -----
// ----------------------------------------------------------------------------
// lbf_ring
// Window sample store with per-entry valid bits; unwritten entries read pad.
// ----------------------------------------------------------------------------
module lbf_ring #(
  parameter int RING_DEPTH = 31,
  parameter int PTR_W      = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lbf_pkg::ring_ctl_t           ctl,
  input  logic [PTR_W-1:0]             addr,
  input  logic [lbf_pkg::SAMPLE_W-1:0] wdata,
  input  logic [lbf_pkg::PAD_W-1:0]    pad,
  output logic [lbf_pkg::SAMPLE_W-1:0] rdata
);
  import lbf_pkg::*;

  logic [SAMPLE_W-1:0]   mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [SAMPLE_W-1:0]   rd_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : pad;

endmodule

// ----- hdl/lbf_div.sv -----
// ----------------------------------------------------------------------------
// lbf_div
// Restoring divider, one quotient bit per cycle, window sum by window depth.
// ----------------------------------------------------------------------------
module lbf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lbf_pkg::SUM_W-1:0]   dividend,
  input  logic [lbf_pkg::DEPTH_W-1:0] divisor,
  output logic [lbf_pkg::SUM_W-1:0]   quotient,
  output lbf_pkg::div_stat_t          stat
);
  import lbf_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0]   quo_r,  quo_nxt;
  logic [DEPTH_W-1:0] rem_r,  rem_nxt;
  logic [DEPTH_W-1:0] dvs_r,  dvs_nxt;
  logic [CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DEPTH_W:0]   trial;
  logic [DEPTH_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DEPTH_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEPTH_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- hdl/line_box_filter_padded.sv -----
// Each accepted item passes the update state and, if it yields a cell, the shared
//   divider and the output state; a line end adds up to r further padded cells.
// A new item is accepted only in the idle state, once every cell of the last one
//   has been taken at the output.
// Reset: synchronous, active low; radius 1, pad 128, empty line, no result.
// ----------------------------------------------------------------------------
// line_box_filter_padded
// Centred box filter along one line with padded ends, shared divider.
// ----------------------------------------------------------------------------
module line_box_filter_padded #(
  parameter int MAX_RADIUS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lbf_in_if.sink                        in_chan,
  lbf_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [lbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lbf_pkg::*;

  localparam int MAX_EFF    = (MAX_RADIUS < 15) ? MAX_RADIUS : 15;
  localparam int RING_DEPTH = 2 * MAX_EFF + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  state_t              state_r,    state_nxt;
  logic [SUM_W-1:0]    sum_r,      sum_nxt;
  logic [PTR_W-1:0]    ptr_r,      ptr_nxt;
  logic [DEPTH_W-1:0]  cs_r,       cs_nxt;
  logic [RADIUS_W-1:0] j_r,        j_nxt;
  logic [SAMPLE_W-1:0] samp_r,     samp_nxt;
  logic                end_r,      end_nxt;
  logic                fresh_r,    fresh_nxt;
  logic [RADIUS_W-1:0] radius_r,   radius_nxt;
  logic [PAD_W-1:0]    pad_r,      pad_nxt;
  logic                ovalid_r,   ovalid_nxt;
  logic [SAMPLE_W-1:0] smoothed_r, smoothed_nxt;
  logic                last_r,     last_nxt;

  logic [RADIUS_W-1:0] r;
  logic [DEPTH_W-1:0]  depth;
  logic [DEPTH_W-1:0]  r1;
  logic [SUM_W-1:0]    init_sum;
  logic [SAMPLE_W-1:0] push_val;
  logic [SAMPLE_W-1:0] old_val;
  logic [7:0]          ptr_inc;
  logic                emit;
  logic                div_start;
  logic [SUM_W-1:0]    quotient;
  div_stat_t           div_st;
  ring_ctl_t           ring_ctl;

  assign r        = (radius_r > RADIUS_W'(MAX_EFF)) ? RADIUS_W'(MAX_EFF) : radius_r;
  assign depth    = {r, 1'b1};
  assign r1       = DEPTH_W'({1'b0, r} + 5'd1);
  assign init_sum = SUM_W'(depth) * SUM_W'(pad_r);
  assign push_val = (j_r == '0) ? samp_r : pad_r;
  assign ptr_inc  = 8'(ptr_r) + 8'd1;

  lbf_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .addr  (ptr_r),
    .wdata (push_val),
    .pad   (pad_r),
    .rdata (old_val)
  );

  lbf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (depth),
    .quotient (quotient),
    .stat     (div_st)
  );

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    ptr_nxt      = ptr_r;
    cs_nxt       = cs_r;
    j_nxt        = j_r;
    samp_nxt     = samp_r;
    end_nxt      = end_r;
    fresh_nxt    = fresh_r;
    radius_nxt   = radius_r;
    pad_nxt      = pad_r;
    ovalid_nxt   = ovalid_r;
    smoothed_nxt = smoothed_r;
    last_nxt     = last_r;
    ring_ctl     = '0;
    div_start    = 1'b0;
    emit         = 1'b0;
    in_chan.ready = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_chan.ready = !(cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_PAD));
        if (fresh_r) begin
          sum_nxt = init_sum;
        end
        if (cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_PAD)) begin
          if (cfg_index == REG_RADIUS) begin
            radius_nxt = cfg_data[RADIUS_W-1:0];
          end else begin
            pad_nxt = cfg_data[PAD_W-1:0];
          end
          fresh_nxt    = 1'b1;
          ptr_nxt      = '0;
          cs_nxt       = '0;
          ring_ctl.clr = 1'b1;
        end else if (in_chan.valid) begin
          samp_nxt    = in_chan.sample;
          end_nxt     = in_chan.line_end;
          j_nxt       = '0;
          ring_ctl.rd = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        sum_nxt     = sum_r + SUM_W'(push_val) - SUM_W'(old_val);
        fresh_nxt   = 1'b0;
        ring_ctl.wr = 1'b1;
        ptr_nxt     = (ptr_inc >= 8'(depth)) ? '0 : PTR_W'(ptr_inc);
        if (j_r == '0) begin
          cs_nxt = (cs_r < r1) ? cs_r + 1'b1 : cs_r;
          emit   = (cs_nxt >= r1);
        end else begin
          emit = ((6'(j_r) + 6'(cs_r)) >= 6'(r1));
        end
        if (emit) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          smoothed_nxt = quotient[SAMPLE_W-1:0];
          last_nxt     = end_r && (j_r == r);
          ovalid_nxt   = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = ST_STEP;
        end
      end
      ST_STEP: begin
        if (end_r && (j_r < r)) begin
          j_nxt       = j_r + 1'b1;
          ring_ctl.rd = 1'b1;
          state_nxt   = ST_UPD;
        end else begin
          if (end_r) begin
            fresh_nxt    = 1'b1;
            ptr_nxt      = '0;
            cs_nxt       = '0;
            ring_ctl.clr = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ptr_r    <= '0;
      cs_r     <= '0;
      j_r      <= '0;
      end_r    <= 1'b0;
      fresh_r  <= 1'b1;
      radius_r <= RADIUS_RST;
      pad_r    <= PAD_RST;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      cs_r     <= cs_nxt;
      j_r      <= j_nxt;
      end_r    <= end_nxt;
      fresh_r  <= fresh_nxt;
      radius_r <= radius_nxt;
      pad_r    <= pad_nxt;
      ovalid_r <= ovalid_nxt;
    end
    sum_r      <= sum_nxt;
    samp_r     <= samp_nxt;
    smoothed_r <= smoothed_nxt;
    last_r     <= last_nxt;
  end

  assign out_chan.valid        = ovalid_r;
  assign out_chan.smoothed     = smoothed_r;
  assign out_chan.last_of_line = last_r;

endmodule

// ----- hdl/lbf_checker.sv -----
// ----------------------------------------------------------------------------
// lbf_checker
// Port-level checks on the filter handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_box_filter_padded_defines.svh"

module lbf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `LBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LBF_ASSERT_NOW(a_no_take_while_out, out_valid, !in_ready)
  `LBF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `LBF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n, !out_valid)

endmodule

bind line_box_filter_padded lbf_checker u_lbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the padded line box filter. Lines of cells are
// streamed in under random burst gaps and output stalls; a local model of the
// window, sum and flush predicts every smoothed cell and its end-of-line
// mark, and each result is compared as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import lbf_pkg::*;

  localparam int  MAX_R         = 15;
  localparam int  RING_LEN      = 2 * MAX_R + 1;
  localparam int  ITEM_TARGET   = 470;
  localparam int  SETTLE_CYCLES = 40;
  localparam int  HOLD_CYCLES   = 400;
  localparam real RUN_LIMIT_NS  = 20_000_000.0;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PATTERN} take_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_of_line;
  } cell_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  lbf_in_if  in_if ();
  lbf_out_if out_if ();

  line_box_filter_padded #(.MAX_RADIUS(MAX_R)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // window model
  logic [RADIUS_W-1:0] cur_radius;
  logic [PAD_W-1:0]    cur_pad;
  logic [SAMPLE_W-1:0] win_ring [RING_LEN];
  int                  win_sum;
  int                  ring_ptr;
  int                  cells_taken;
  cell_t               expected_cells [$];

  int         errors;
  int         items_sent;
  int         lines_done;
  int         cells_checked;
  int         burst_left;
  bit         sender_gappy;
  take_mode_t take_mode;
  logic [7:0] take_pattern = 8'b1011_0110;
  int         hold_request;
  int         hold_left;

  function automatic int eff_radius();
    return (cur_radius > MAX_R) ? MAX_R : int'(cur_radius);
  endfunction

  function automatic void restart_line();
    for (int k = 0; k < RING_LEN; k++) win_ring[k] = cur_pad;
    win_sum     = (2 * eff_radius() + 1) * cur_pad;
    ring_ptr    = 0;
    cells_taken = 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] push_window(input logic [SAMPLE_W-1:0] value);
    int depth;
    int p;
    depth   = 2 * eff_radius() + 1;
    p       = (ring_ptr < depth) ? ring_ptr : 0;
    win_sum = win_sum + value - win_ring[p];
    win_ring[p] = value;
    p++;
    ring_ptr = (p >= depth) ? 0 : p;
    return SAMPLE_W'(win_sum / depth);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_RADIUS: begin
        cur_radius = data[RADIUS_W-1:0];
        restart_line();
      end
      REG_PAD: begin
        cur_pad = data[PAD_W-1:0];
        restart_line();
      end
      default: ;
    endcase
  endfunction

  // one accepted item; the last cell it yields carries the line end mark
  function automatic void predict_cells(input logic [SAMPLE_W-1:0] value, input logic ends);
    int    r;
    int    j;
    bit    have_held;
    cell_t held;
    cell_t c;
    r         = eff_radius();
    have_held = 0;
    c.last_of_line = 1'b0;
    c.smoothed = push_window(value);
    if (cells_taken < r + 1) cells_taken++;
    if (cells_taken >= r + 1) begin
      held      = c;
      have_held = 1;
    end
    if (ends) begin
      for (j = 1; j <= r; j++) begin
        c.smoothed = push_window(cur_pad);
        if (j + cells_taken >= r + 1) begin
          if (have_held) expected_cells.push_back(held);
          held      = c;
          have_held = 1;
        end
      end
    end
    if (have_held) begin
      held.last_of_line = ends;
      expected_cells.push_back(held);
    end
    if (ends) begin
      restart_line();
      lines_done++;
    end
    items_sent++;
  endfunction

  task automatic send_cell(input logic [SAMPLE_W-1:0] value, input logic ends);
    int gap;
    @(negedge clk);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (sender_gappy) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.sample   <= value;
    in_if.line_end <= ends;
    do @(posedge clk); while (!in_if.ready);
    predict_cells(value, ends);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  task automatic send_line(input logic [SAMPLE_W-1:0] cells [$], input bit closed);
    foreach (cells[k]) send_cell(cells[k], closed && (k == cells.size() - 1));
    stop_sending();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: stall pattern plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      case (take_mode)
        TAKE_ALWAYS: out_if.ready <= 1'b1;
        TAKE_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_if.ready <= take_pattern[0];
          take_pattern = {take_pattern[0], take_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_cells
    cell_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      cells_checked++;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected cell, expected none, actual smoothed %0d last %0b",
                 $time, out_if.smoothed, out_if.last_of_line);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_if.smoothed !== want.smoothed) begin
          $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                   $time, want.smoothed, out_if.smoothed);
          errors++;
        end
        if (out_if.last_of_line !== want.last_of_line) begin
          $display("%0t: last_of_line mismatch, expected %0b, actual %0b",
                   $time, want.last_of_line, out_if.last_of_line);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_settings();
    send_line('{8'd0, 8'd255, 8'd17}, 1);
  endtask

  task automatic test_passthrough();
    wait_idle();
    write_reg(REG_RADIUS, 8'hA0); // upper bits masked: radius 0
    write_reg(REG_PAD, 8'd0);
    send_line('{8'd255, 8'd0, 8'd1}, 1);
  endtask

  task automatic test_line_shorter_than_radius();
    wait_idle();
    write_reg(REG_RADIUS, 8'd15);
    write_reg(REG_PAD, 8'd255);
    send_line('{8'd0}, 1);
    wait_idle();
    write_reg(REG_PAD, 8'd0);
    send_line('{8'd255, 8'd255}, 1);
  endtask

  task automatic test_partial_line_dropped();
    wait_idle();
    write_reg(REG_RADIUS, 8'h52); // radius 2
    write_reg(REG_PAD, 8'd10);
    send_line('{8'd200, 8'd201, 8'd202, 8'd203}, 0);
    wait_idle();
    write_reg(REG_PAD, 8'd10);    // same value still restarts the line
    send_line('{8'd7}, 1);
  endtask

  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_RADIUS, 8'd1);
    send_line('{8'd50, 8'd60}, 0);
    wait_idle();
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    send_line('{8'd70}, 1);
  endtask

  task automatic test_output_hold_off();
    logic [SAMPLE_W-1:0] cells [$];
    wait_idle();
    write_reg(REG_PAD, 8'd99);
    sender_gappy = 0;
    take_mode    = TAKE_ALWAYS;
    for (int k = 0; k < 8; k++) cells.push_back(SAMPLE_W'($urandom));
    hold_request = HOLD_CYCLES;
    send_line(cells, 1);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int style);
    int v;
    case (style)
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: begin
        v = int'(cur_pad) + $urandom_range(0, 8) - 4;
        return SAMPLE_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
      end
    endcase
  endfunction

  task automatic test_random_lines();
    int                  r;
    int                  pick;
    int                  n_lines;
    int                  len;
    int                  style;
    bit                  partial;
    logic [PAD_W-1:0]    pad;
    logic [SAMPLE_W-1:0] cells [$];
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      r    = (pick < 2) ? 0 : (pick < 4) ? 15 : (pick < 5) ? $urandom_range(5, 14)
           : $urandom_range(1, 4);
      pick = $urandom_range(0, 3);
      pad  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : PAD_W'($urandom);
      pick = $urandom_range(0, 5);
      if (pick != 0) write_reg(REG_RADIUS, {4'($urandom), 4'(r)});
      if (pick != 1) write_reg(REG_PAD, pad);
      r            = eff_radius();
      take_mode    = take_mode_t'($urandom_range(0, 2));
      sender_gappy = $urandom_range(0, 2) != 0;
      n_lines      = $urandom_range(1, 4);
      for (int ln = 0; ln < n_lines; ln++) begin
        cells.delete();
        len     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                               : $urandom_range(1, 2 * r + 4);
        style   = $urandom_range(0, 4);
        style   = (style < 3) ? 0 : style - 2;
        partial = (ln == n_lines - 1) && ($urandom_range(0, 5) == 0);
        for (int k = 0; k < len; k++) cells.push_back(pick_sample(style));
        send_line(cells, !partial);
        if (partial && $urandom_range(0, 1) == 1) begin
          // spare index mid-line: the line must carry on
          wait_idle();
          write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DAT_W'($urandom));
          cells.delete();
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++) cells.push_back(pick_sample(0));
          send_line(cells, 1);
        end
      end
    end
  endtask

  initial begin : run
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.sample   = '0;
    in_if.line_end = 1'b0;
    out_if.ready   = 1'b0;
    errors         = 0;
    items_sent     = 0;
    lines_done     = 0;
    cells_checked  = 0;
    burst_left     = 0;
    hold_request   = 0;
    hold_left      = 0;
    sender_gappy   = 1;
    take_mode      = TAKE_RANDOM;
    cur_radius     = RADIUS_RST;
    cur_pad        = PAD_RST;
    restart_line();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_passthrough();
    test_line_shorter_than_radius();
    test_partial_line_dropped();
    test_spare_index();
    test_output_hold_off();
    test_random_lines();
    wait_idle();

    $display("Run covered %0d items over %0d closed lines, %0d smoothed cells checked,",
             items_sent, lines_done, cells_checked);
    $display("radius 0 to 15, pads 0 and 255, dropped partial lines and a long output hold.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d cells outstanding", expected_cells.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lbf_pkg.sv
hdl/lbf_in_if.sv
hdl/lbf_out_if.sv
hdl/lbf_ring.sv
hdl/lbf_div.sv
hdl/line_box_filter_padded.sv
hdl/lbf_checker.sv
test/tb_top.sv
